@@ rtl/whhr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whhr_pkg: shared constants of the weight heat-map HSV to RGB core.
// Register indexes and hue sector codes used by the core and its stages.
// ----------------------------------------------------------------------------
package whhr_pkg;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b1;

  // Hue sectors. The hue never reaches 240 degrees, so two bits cover
  // every sector that can occur.
  localparam int SECTOR_W = 2;
  localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW  = 2'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN = 2'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN  = 2'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE   = 2'd3;

endpackage

@@ rtl/weight_heatmap_hsv_to_rgb_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_heatmap_hsv_to_rgb_core: heat-map colorizer.
// Maps a normalized weight to a hue and converts it to RGB in fixed point.
// ----------------------------------------------------------------------------
// Each input beat carries a weight in unsigned fixed point with FRAC_BITS
// fraction bits, where 2^FRAC_BITS stands for 1.0. The weight sets a hue of
// (1 - w) * 234 degrees, so zero maps to blue and one maps to red, and the
// saturation and brightness registers complete the HSV triple. The core
// takes one beat every clock cycle when the output side is not stalled,
// and returns one RGB beat for each, in order. It has five register
// stages: input clamping with the chroma product, a reciprocal multiply
// for the divide by ten, the remainder fix-up that splits the hue into
// sector and fraction, the X product, and the channel mixing into the
// output register. Each stage holds its beat while the next one is full,
// so back-pressure on the output ripples back to s_axis_tready without
// dropping or repeating data.
// Weights and register values above 1.0 are clamped to 1.0 when used, and
// every channel saturates at 1.0. Configuration writes are always taken;
// they must be issued only while no beat is in flight.
// ----------------------------------------------------------------------------
module weight_heatmap_hsv_to_rgb_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream: tdata = weight.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((FRAC_BITS+8)/8)*8-1:0]        s_axis_tdata,
  // Output stream: tdata = red, green, blue, zero padding.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((3*FRAC_BITS+10)/8)*8-1:0]     m_axis_tdata,
  // Configuration writes: index 0 saturation, index 1 brightness.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [whhr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [FRAC_BITS:0]                    cfg_data
);
  import whhr_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int OW = ((3*FRAC_BITS+10)/8)*8;
  // Reset level for both registers, 0.8 rounded to nearest.
  localparam logic [F:0] RESET_LEVEL =
    (F+1)'((((F+4)'(1) << F) * 8 + 5) / 10);

  logic [F:0] saturation;
  logic [F:0] brightness;

  logic                 mid_valid, mid_ready;
  logic [SECTOR_W-1:0]  mid_sector;
  logic [F:0]           mid_factor, mid_chroma, mid_offset;
  logic [F:0]           red, green, blue;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= RESET_LEVEL;
      brightness <= RESET_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SATURATION: saturation <= cfg_data;
        REG_BRIGHTNESS: brightness <= cfg_data;
        default: begin
          saturation <= saturation;
        end
      endcase
    end
  end

  whhr_hue #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .weight     (s_axis_tdata[F:0]),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .sector     (mid_sector),
    .factor     (mid_factor),
    .chroma     (mid_chroma),
    .offset     (mid_offset)
  );

  whhr_rgb #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rgb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .sector    (mid_sector),
    .factor    (mid_factor),
    .chroma    (mid_chroma),
    .offset    (mid_offset),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // Channels packed from the low end, padding bits are zero.
  assign m_axis_tdata = OW'({blue, green, red});

endmodule

@@ rtl/whhr_hue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whhr_hue: hue and chroma front end.
// Three register stages: clamping, chroma product and hue scaling by 39;
// reciprocal multiply for the divide by ten; remainder fix-up and sector split.
// ----------------------------------------------------------------------------
module whhr_hue #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [FRAC_BITS:0]                  weight,
  input  logic [FRAC_BITS:0]                  saturation,
  input  logic [FRAC_BITS:0]                  brightness,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [whhr_pkg::SECTOR_W-1:0]       sector,
  output logic [FRAC_BITS:0]                  factor,
  output logic [FRAC_BITS:0]                  chroma,
  output logic [FRAC_BITS:0]                  offset
);
  import whhr_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 6;          // holds (ONE - w) * 39
  localparam int S  = F + 10;         // reciprocal scale
  localparam int KW = S - 3;
  localparam int PW = AW + KW;
  localparam int QW = F + 2;          // hue in sector units, below 4.0
  localparam logic [F:0]  ONE = (F+1)'(1) << F;
  localparam logic [S:0]  POW = (S+1)'(1) << S;
  localparam logic [KW-1:0] RECIP10 = KW'(POW / 10);

  // Stage 1
  logic           v1;
  logic [AW-1:0]  a1;
  logic [F:0]     c1;
  logic [F:0]     b1;
  // Stage 2
  logic           v2;
  logic [AW-1:0]  a2;
  logic [QW-1:0]  q2;
  logic [F:0]     c2;
  logic [F:0]     m2;
  // Stage 3
  logic           v3;

  logic rdy1, rdy2, rdy3;

  logic [F:0]       w_cl, s_cl, b_cl, diff;
  logic [AW-1:0]    a_next;
  logic [2*F+1:0]   vs_prod;
  logic [PW-1:0]    recip_prod;
  logic [AW-1:0]    ten_q, rem;
  logic [QW-1:0]    hue_q;
  logic [F-1:0]     frac;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_comb begin
    w_cl    = (weight > ONE) ? ONE : weight;
    s_cl    = (saturation > ONE) ? ONE : saturation;
    b_cl    = (brightness > ONE) ? ONE : brightness;
    diff    = ONE - w_cl;
    // Times 39 as shifts and adds.
    a_next  = (AW'(diff) << 5) + (AW'(diff) << 2) + (AW'(diff) << 1) + AW'(diff);
    vs_prod = (2*F+2)'(b_cl) * (2*F+2)'(s_cl);
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign recip_prod = PW'(a1) * PW'(RECIP10);

  always_comb begin
    ten_q = (AW'(q2) << 3) + (AW'(q2) << 1);
    rem   = a2 - ten_q;
    hue_q = q2 + QW'(rem >= AW'(10));
    frac  = hue_q[F-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      a1 <= a_next;
      c1 <= vs_prod[2*F:F];
      b1 <= b_cl;
    end
    if (v1 && rdy2) begin
      a2 <= a1;
      q2 <= recip_prod[S+QW-1:S];
      c2 <= c1;
      m2 <= b1 - c1;
    end
    if (v2 && rdy3) begin
      sector <= hue_q[F+SECTOR_W-1:F];
      factor <= hue_q[F] ? (ONE - (F+1)'(frac)) : (F+1)'(frac);
      chroma <= c2;
      offset <= m2;
    end
  end

endmodule

@@ rtl/whhr_rgb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whhr_rgb: RGB back end.
// Two register stages: the X product, then sector permutation, offset add
// and saturation into the output register.
// ----------------------------------------------------------------------------
module whhr_rgb #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [whhr_pkg::SECTOR_W-1:0] sector,
  input  logic [FRAC_BITS:0]            factor,
  input  logic [FRAC_BITS:0]            chroma,
  input  logic [FRAC_BITS:0]            offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRAC_BITS:0]            red,
  output logic [FRAC_BITS:0]            green,
  output logic [FRAC_BITS:0]            blue
);
  import whhr_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic                 v4, v5;
  logic [SECTOR_W-1:0]  sec4;
  logic [F:0]           x4, c4, m4;
  logic                 rdy4, rdy5;

  logic [2*F+1:0] x_prod;
  logic [F:0]     r_raw, g_raw, b_raw;
  logic [F+1:0]   r_sum, g_sum, b_sum;

  assign rdy5      = !v5 || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v5;

  assign x_prod = (2*F+2)'(chroma) * (2*F+2)'(factor);

  always_comb begin
    r_raw = '0;
    g_raw = '0;
    b_raw = '0;
    case (sec4)
      SECTOR_RED_YELLOW: begin
        r_raw = c4;
        g_raw = x4;
      end
      SECTOR_YELLOW_GREEN: begin
        r_raw = x4;
        g_raw = c4;
      end
      SECTOR_GREEN_CYAN: begin
        g_raw = c4;
        b_raw = x4;
      end
      SECTOR_CYAN_BLUE: begin
        g_raw = x4;
        b_raw = c4;
      end
      default: begin
        r_raw = '0;
      end
    endcase
    r_sum = (F+2)'(r_raw) + (F+2)'(m4);
    g_sum = (F+2)'(g_raw) + (F+2)'(m4);
    b_sum = (F+2)'(b_raw) + (F+2)'(m4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy4) begin
      sec4 <= sector;
      x4   <= x_prod[2*F:F];
      c4   <= chroma;
      m4   <= offset;
    end
    if (v4 && rdy5) begin
      red   <= (r_sum > (F+2)'(ONE)) ? ONE : r_sum[F:0];
      green <= (g_sum > (F+2)'(ONE)) ? ONE : g_sum[F:0];
      blue  <= (b_sum > (F+2)'(ONE)) ? ONE : b_sum[F:0];
    end
  end

endmodule

@@ verif/weight_heatmap_hsv_to_rgb_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_heatmap_hsv_to_rgb_core_test: self-checking bench for the colorizer.
// Streams weights through the core under random stalls on both sides and
// checks every RGB beat against a bit-exact fixed-point color predictor.
// ----------------------------------------------------------------------------
module weight_heatmap_hsv_to_rgb_core_test;
  import whhr_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W = FRAC_BITS + 1;
  localparam bit [63:0] UNIT = 64'd1 << FRAC_BITS;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  localparam int IN_W = ((FRAC_BITS + 8) / 8) * 8;
  localparam int OUT_W = ((3 * FRAC_BITS + 10) / 8) * 8;
  // The core has five register stages; this leaves a comfortable margin.
  localparam int DRAIN_CYCLES = 12;
  // Longest legal quiet stretch is a few stall cycles plus a drain pause.
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 62;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the core starts from a known value.
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;   // [16:0] weight, zero padding above
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // [16:0] red, [33:17] green,
                                             // [50:34] blue, zero padding above
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SATURATION;
  logic [FRAC_BITS:0]   cfg_data = '0;

  weight_heatmap_hsv_to_rgb_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copies of the two registers, as last written into the core.
  logic [FIELD_W-1:0] saturation_reg = 17'd52429;
  logic [FIELD_W-1:0] brightness_reg = 17'd52429;

  // Weights waiting to be driven, and the colors owed by the core.
  logic [FIELD_W-1:0] weight_queue[$];
  rgb_t               color_queue[$];

  // Handshake flags, refreshed at each rising edge and read by the
  // drivers at the following falling edge.
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  bit                 in_busy = 1'b0;
  bit                 send_burst = 1'b0;
  bit                 recv_burst = 1'b0;
  int                 send_gap = 0;
  int                 recv_wait = 0;
  logic [FIELD_W-1:0] cur_weight = '0;

  int errors = 0;
  int weights_sent = 0;
  int weights_over_one = 0;
  int colors_checked = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Bit-exact color prediction. The hue is (1 - w) * 234 degrees, so the
  // hue in sector units is (1 - w) * 3.9, truncated to FRAC_BITS fraction
  // bits. Every product drops its low fraction bits, and each channel is
  // clipped at one after the offset M = V - C is added.
  function automatic rgb_t hsv_color(input logic [FIELD_W-1:0] weight,
                                     input logic [FIELD_W-1:0] sat_raw,
                                     input logic [FIELD_W-1:0] bri_raw);
    bit [63:0] w, s, v, chroma, offset, hue, frac, x, r, g, b;
    bit [63:0] sector;
    rgb_t      color;
    // Weights and register values above one count as exactly one.
    w = (weight > UNIT) ? UNIT : 64'(weight);
    s = (sat_raw > UNIT) ? UNIT : 64'(sat_raw);
    v = (bri_raw > UNIT) ? UNIT : 64'(bri_raw);
    chroma = (v * s) >> FRAC_BITS;
    offset = v - chroma;
    hue = ((UNIT - w) * 64'd39) / 64'd10;
    sector = (hue >> FRAC_BITS) % 64'd6;
    frac = hue & (UNIT - 64'd1);
    // X rises through even sectors and falls through odd ones.
    if (sector[0])
      x = (chroma * (UNIT - frac)) >> FRAC_BITS;
    else
      x = (chroma * frac) >> FRAC_BITS;
    case (sector)
      64'd0: begin r = chroma; g = x; b = 0; end
      64'd1: begin r = x; g = chroma; b = 0; end
      64'd2: begin r = 0; g = chroma; b = x; end
      64'd3: begin r = 0; g = x; b = chroma; end
      64'd4: begin r = x; g = 0; b = chroma; end
      64'd5: begin r = chroma; g = 0; b = x; end
      default: begin r = 0; g = 0; b = 0; end
    endcase
    r = r + offset;
    g = g + offset;
    b = b + offset;
    color.red   = (r > UNIT) ? FIELD_W'(UNIT) : FIELD_W'(r);
    color.green = (g > UNIT) ? FIELD_W'(UNIT) : FIELD_W'(g);
    color.blue  = (b > UNIT) ? FIELD_W'(UNIT) : FIELD_W'(b);
    return color;
  endfunction

  // Mostly in-range weights, with a share of exact ends, weights above one
  // and weights right at the edges between hue sectors.
  function automatic logic [FIELD_W-1:0] random_weight();
    int pick;
    int edge_idx;
    int near;
    pick = $urandom_range(0, 15);
    edge_idx = $urandom_range(1, 3);
    near = $urandom_range(0, 8);
    case (pick)
      0: return '0;
      1: return FIELD_W'(UNIT);
      2, 3: return FIELD_W'($urandom_range(int'(UNIT) + 1, int'(FIELD_MAX)));
      // Sector k starts where (1 - w) * 3.9 reaches k, near w = 1 - k / 3.9.
      4: return FIELD_W'(int'(UNIT) - (edge_idx * int'(UNIT) * 10) / 39 + near - 4);
      default: return FIELD_W'($urandom_range(0, int'(UNIT)));
    endcase
  endfunction

  task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Appends one weight at the tail of the sender's pending list.
  task automatic add_weight(input logic [FIELD_W-1:0] value);
    weight_queue.insert(weight_queue.size(), value);
  endtask

  // One register write on the configuration channel; the shadow copy
  // follows once the core has taken the beat.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SATURATION)
      saturation_reg = value;
    else
      brightness_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [FIELD_W-1:0] sat,
                               input logic [FIELD_W-1:0] bri);
    write_register(REG_SATURATION, sat);
    write_register(REG_BRIGHTNESS, bri);
    settings_used++;
  endtask

  // Waits until every queued weight is sent and every owed color has arrived,
  // then lets the pipeline settle so that a register write cannot catch a beat in flight.
  task automatic drain_core();
    @(posedge clk);
    while (weight_queue.size() != 0 || in_busy || color_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) add_weight(random_weight());
    drain_core();
  endtask

  // Sender: the next weight goes out after a random gap, except during
  // bursts, where weights follow back to back.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_busy && in_taken) begin
        in_busy = 1'b0;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (weight_queue.size() > 0) begin
          cur_weight = weight_queue.pop_front();
          in_busy = 1'b1;
        end
      end
    end
    s_axis_tvalid <= in_busy;
    s_axis_tdata <= IN_W'(cur_weight);
  end

  // Receiver: after each color beat, tready drops for a random stretch, with
  // stretches of no stalling at all.
  always @(negedge clk) begin
    if (!rst && out_taken) begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      recv_wait = recv_burst ? 0 : $urandom_range(0, 4);
    end
    if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: records each accepted weight with its predicted color, checks
  // each color beat against the oldest prediction, and watches for a hang.
  always @(posedge clk) begin : monitor
    rgb_t               want;
    logic [FIELD_W-1:0] weight;
    if (rst) begin
      in_taken = 1'b0;
      out_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (in_taken) begin
        weight = s_axis_tdata[FIELD_W-1:0];
        color_queue.insert(color_queue.size(),
                           hsv_color(weight, saturation_reg, brightness_reg));
        weights_sent++;
        if (weight > UNIT) weights_over_one++;
      end
      if (out_taken) begin
        if (color_queue.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: color beat with none expected, expected nothing, actual %h",
                     $time, m_axis_tdata);
        end else begin
          want = color_queue.pop_front();
          colors_checked++;
          if (m_axis_tdata[FIELD_W-1:0] !== want.red)
            report_field("red", want.red, m_axis_tdata[FIELD_W-1:0]);
          if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.green)
            report_field("green", want.green, m_axis_tdata[2*FIELD_W-1:FIELD_W]);
          if (m_axis_tdata[3*FIELD_W-1:2*FIELD_W] !== want.blue)
            report_field("blue", want.blue, m_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
        end
      end
      if (in_taken || out_taken || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d colors still owed",
                 $time, idle_cycles, color_queue.size());
        $display("weight_heatmap_hsv_to_rgb_core test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] rnd_sat;
    logic [FIELD_W-1:0] rnd_bri;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed weights under the reset register values: both ends of the
    // range, every bit of the field high and low, weights above one that
    // must clamp to red, and weights on each side of the three sector edges.
    add_weight(17'd0);
    add_weight(17'd1);
    add_weight(17'd65535);
    add_weight(17'd65536);
    add_weight(17'd65537);
    add_weight(17'h1FFFF);
    add_weight(17'h15555);
    add_weight(17'h0AAAA);
    add_weight(17'd32768);
    add_weight(17'd48731);
    add_weight(17'd48732);
    add_weight(17'd48733);
    add_weight(17'd31927);
    add_weight(17'd31928);
    add_weight(17'd31929);
    add_weight(17'd15123);
    add_weight(17'd15124);
    add_weight(17'd15125);
    send_random(RANDOM_PER_PHASE);

    // Register extremes: full and zero saturation and brightness, values
    // above one that must clamp, and the mixed corners.
    apply_setting(17'd65536, 17'd65536);
    add_weight(17'd0);
    add_weight(17'd65536);
    send_random(RANDOM_PER_PHASE);
    apply_setting(17'd0, 17'd0);
    send_random(RANDOM_PER_PHASE);
    apply_setting(FIELD_MAX, FIELD_MAX);
    add_weight(17'd0);
    send_random(RANDOM_PER_PHASE);
    apply_setting(17'd0, 17'd65536);
    send_random(RANDOM_PER_PHASE);
    apply_setting(17'd65536, 17'd0);
    send_random(RANDOM_PER_PHASE);
    apply_setting(17'd1, 17'd65535);
    send_random(RANDOM_PER_PHASE);

    // Random settings, one pair of them above one.
    repeat (2) begin
      rnd_sat = FIELD_W'($urandom_range(0, int'(UNIT)));
      rnd_bri = FIELD_W'($urandom_range(0, int'(UNIT)));
      apply_setting(rnd_sat, rnd_bri);
      send_random(RANDOM_PER_PHASE);
    end
    rnd_sat = FIELD_W'($urandom_range(int'(UNIT) + 1, int'(FIELD_MAX)));
    rnd_bri = FIELD_W'($urandom_range(int'(UNIT) + 1, int'(FIELD_MAX)));
    apply_setting(rnd_sat, rnd_bri);
    send_random(RANDOM_PER_PHASE);

    // Back to the power-on values.
    apply_setting(17'd52429, 17'd52429);
    send_random(RANDOM_PER_PHASE);

    $display("Streamed %0d weights (%0d above one) under %0d register settings;",
             weights_sent, weights_over_one, settings_used);
    $display("checked %0d colors, %0d field errors.", colors_checked, errors);
    if (errors == 0 && color_queue.size() == 0)
      $display("weight_heatmap_hsv_to_rgb_core test passed");
    else
      $display("weight_heatmap_hsv_to_rgb_core test failed");
    $finish;
  end

endmodule
